[rtl/core/bsb_pkg.sv]
// Shared types and constants for the bounded stack bank.
// Used by every module under rtl/core; depends on nothing else.
`timescale 1ns / 1ps

package bsb_pkg;

   localparam int DATA_W         = 32;
   localparam int KIND_W         = 2;
   localparam int INDEX_W        = 8;
   localparam int TOUCH_W        = 4;
   localparam int CFG_W          = 5;
   localparam int NUM_STACKS_DEF = 16;
   localparam int MAX_CAP_DEF    = 16;

   localparam logic [CFG_W-1:0] CAPACITY_RESET = 5'd16;

   localparam logic [KIND_W-1:0] KIND_PUSH   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_POP    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_POP_AT = 2'd2;

   // Outcome of one request, decided when it is taken.
   typedef struct packed {
      logic               pop_hit;
      logic               was_empty;
      logic               push_dropped;
      logic [TOUCH_W-1:0] stack_touched;
   } issue_type;

endpackage

[rtl/core/bounded_stack_bank.sv]
// Bounded stack bank top level: request/response streams, capacity register.
// Depends on bsb_pkg, bsb_fill_ctrl and bsb_plate_ram.
//
// A bank of NUM_STACKS LIFO stacks, each holding up to the programmed
// capacity (clamped to 1..MAX_CAPACITY). Requests arrive on req_*: tuser
// carries the kind (push, pop from the rightmost nonempty stack, pop at
// stack_index), tdata the push value and stack index. Every request gives
// exactly one response on rsp_*: the popped value and touched stack index in
// tdata, the was_empty and push_dropped flags in tuser.
// The fill counts and priority encoders decide the target and issue one
// plate memory access in the transfer cycle; the registered read data then
// moves from the read stage into the response register, so rsp_tvalid
// rises once the request has passed both registers. Fill counts update at
// transfer, so one request per cycle is taken while the receiver keeps up.
// When rsp_tready is low the response holds in its register, one further
// request may finish into the read stage, then req_tready drops.
// Reset clears all fill counts at once and sets capacity to 16; plate
// memory needs no clearing since only written entries are ever read.
// csr_wr_en writes csr_wr_data into the capacity register; write it only
// while no request is in flight.
`timescale 1ns / 1ps

module bounded_stack_bank #(
   parameter int NUM_STACKS   = bsb_pkg::NUM_STACKS_DEF,
   parameter int MAX_CAPACITY = bsb_pkg::MAX_CAP_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // [31:0] push_value, [39:32] stack_index
   input  logic [39:0]                 req_tdata,
   // [1:0] kind
   input  logic [1:0]                  req_tuser,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // [31:0] popped_value, [35:32] stack_touched, [39:36] zero
   output logic [39:0]                 rsp_tdata,
   // [0] was_empty, [1] push_dropped
   output logic [1:0]                  rsp_tuser,
   input  logic                        csr_wr_en,
   input  logic [bsb_pkg::CFG_W-1:0]   csr_wr_data
);

   localparam int Depth = NUM_STACKS * MAX_CAPACITY;
   localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;

   logic [bsb_pkg::CFG_W-1:0]  capacity_ff;
   logic                       take;
   logic                       s1_advance;
   bsb_pkg::issue_type         issue;
   logic                       mem_we;
   logic                       mem_re;
   logic [AW-1:0]              mem_addr;
   logic [bsb_pkg::DATA_W-1:0] rd_data;

   logic                       s1_valid_ff;
   logic                       s1_valid_in;
   bsb_pkg::issue_type         s1_info_ff;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic [bsb_pkg::DATA_W-1:0] rsp_value_ff;
   logic [bsb_pkg::DATA_W-1:0] rsp_value_in;
   bsb_pkg::issue_type         rsp_info_ff;
   logic                       rsp_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= bsb_pkg::CAPACITY_RESET;
      end else if (csr_wr_en) begin
         capacity_ff <= csr_wr_data;
      end
   end

   assign s1_advance = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || s1_advance;
   assign take       = req_tvalid && req_tready;
   assign rsp_load   = s1_valid_ff && s1_advance;

   bsb_fill_ctrl #(
      .NUM_STACKS   (NUM_STACKS),
      .MAX_CAPACITY (MAX_CAPACITY),
      .AW           (AW)
   ) u_fill_ctrl (
      .clock       (clock),
      .reset       (reset),
      .capacity    (capacity_ff),
      .take        (take),
      .kind        (req_tuser),
      .stack_index (req_tdata[39:32]),
      .issue       (issue),
      .mem_we      (mem_we),
      .mem_re      (mem_re),
      .mem_addr    (mem_addr)
   );

   bsb_plate_ram #(
      .DEPTH (Depth),
      .AW    (AW)
   ) u_plate_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .rd_en   (mem_re),
      .addr    (mem_addr),
      .wr_data (req_tdata[31:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (take) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      // zero the value unless a pop hit
      rsp_value_in = s1_info_ff.pop_hit ? rd_data : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_info_ff <= issue;
      end
      if (rsp_load) begin
         rsp_value_ff <= rsp_value_in;
         rsp_info_ff  <= s1_info_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_info_ff.stack_touched, rsp_value_ff};
   assign rsp_tuser  = {rsp_info_ff.push_dropped, rsp_info_ff.was_empty};

`ifndef SYNTHESIS
   a_s1_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      (take && s1_valid_ff) |-> s1_advance)
      else $error("read stage overwritten while its response is blocked");

   a_mem_one_port : assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re))
      else $error("plate memory read and write issued together");

   a_flags_exclusive : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("response flags empty and dropped both set");

   a_empty_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser[0] || rsp_tuser[1])) |-> (rsp_tdata[35:0] == 36'd0))
      else $error("flagged response carries a value or stack index");
`endif

endmodule

[rtl/core/bsb_plate_ram.sv]
// Plate storage: one synchronous single-port memory with a registered read.
// Depends on bsb_pkg for the data width.
`timescale 1ns / 1ps

module bsb_plate_ram #(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic                        rd_en,
   input  logic [AW-1:0]               addr,
   input  logic [bsb_pkg::DATA_W-1:0]  wr_data,
   output logic [bsb_pkg::DATA_W-1:0]  rd_data
);

   logic [bsb_pkg::DATA_W-1:0] plate_mem_ff [DEPTH];
   logic [bsb_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         plate_mem_ff[addr] <= wr_data;
      end
      // hold read data until the next read
      if (rd_en) begin
         rd_data_ff <= plate_mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/bsb_fill_ctrl.sv]
// Fill counts per stack, full/nonempty priority encoders and plate address issue.
// Depends on bsb_pkg for kind codes and the issue_type struct.
`timescale 1ns / 1ps

module bsb_fill_ctrl #(
   parameter int NUM_STACKS   = bsb_pkg::NUM_STACKS_DEF,
   parameter int MAX_CAPACITY = bsb_pkg::MAX_CAP_DEF,
   parameter int AW           = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [bsb_pkg::CFG_W-1:0]    capacity,
   input  logic                         take,
   input  logic [bsb_pkg::KIND_W-1:0]   kind,
   input  logic [bsb_pkg::INDEX_W-1:0]  stack_index,
   output bsb_pkg::issue_type           issue,
   output logic                         mem_we,
   output logic                         mem_re,
   output logic [AW-1:0]                mem_addr
);

   localparam int SW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
   localparam int CW = $clog2(MAX_CAPACITY + 1);
   localparam logic [AW-1:0] Stride = AW'(MAX_CAPACITY);

   logic [CW-1:0]         count_ff [NUM_STACKS];
   logic [NUM_STACKS-1:0] full;
   logic [NUM_STACKS-1:0] nonempty;
   logic [8:0]            cap_wide;
   logic [SW-1:0]         push_sel;
   logic                  push_found;
   logic [SW-1:0]         pop_sel;
   logic                  pop_found;
   logic [SW-1:0]         at_sel;
   logic                  at_ok;
   logic [SW-1:0]         target;
   logic                  do_push;
   logic                  do_pop;
   logic [CW-1:0]         cur_count;
   logic [CW-1:0]         slot;
   logic [CW-1:0]         count_in;

   // clamp capacity to 1..MAX_CAPACITY
   always_comb begin
      cap_wide = 9'(capacity);
      if (cap_wide == 9'd0) begin
         cap_wide = 9'd1;
      end else if (cap_wide > 9'(MAX_CAPACITY)) begin
         cap_wide = 9'(MAX_CAPACITY);
      end
   end

   always_comb begin
      for (int s = 0; s < NUM_STACKS; s++) begin
         full[s]     = 9'(count_ff[s]) >= cap_wide;
         nonempty[s] = count_ff[s] != '0;
      end
   end

   // leftmost stack that is not full
   always_comb begin
      push_found = 1'b0;
      push_sel   = '0;
      for (int s = NUM_STACKS - 1; s >= 0; s--) begin
         if (!full[s]) begin
            push_found = 1'b1;
            push_sel   = SW'(s);
         end
      end
   end

   // rightmost stack that is not empty
   always_comb begin
      pop_found = 1'b0;
      pop_sel   = '0;
      for (int s = 0; s < NUM_STACKS; s++) begin
         if (nonempty[s]) begin
            pop_found = 1'b1;
            pop_sel   = SW'(s);
         end
      end
   end

   assign at_sel = SW'(stack_index);
   assign at_ok  = (9'(stack_index) < 9'(NUM_STACKS)) && nonempty[at_sel];

   always_comb begin
      target  = '0;
      do_push = 1'b0;
      do_pop  = 1'b0;
      issue   = '0;
      case (kind)
         bsb_pkg::KIND_PUSH: begin
            target             = push_sel;
            do_push            = push_found;
            issue.push_dropped = !push_found;
         end
         bsb_pkg::KIND_POP: begin
            target          = pop_sel;
            do_pop          = pop_found;
            issue.was_empty = !pop_found;
         end
         bsb_pkg::KIND_POP_AT: begin
            target          = at_sel;
            do_pop          = at_ok;
            issue.was_empty = !at_ok;
         end
         default: begin
         end
      endcase
      issue.pop_hit = do_pop;
      if (do_push || do_pop) begin
         issue.stack_touched = bsb_pkg::TOUCH_W'(target);
      end
   end

   assign cur_count = count_ff[target];
   assign slot      = do_pop ? cur_count - CW'(1) : cur_count;
   assign count_in  = do_pop ? cur_count - CW'(1) : cur_count + CW'(1);
   assign mem_we    = take && do_push;
   assign mem_re    = take && do_pop;
   assign mem_addr  = AW'(target) * Stride + AW'(slot);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NUM_STACKS; s++) begin
            count_ff[s] <= '0;
         end
      end else if (take && (do_push || do_pop)) begin
         count_ff[target] <= count_in;
      end
   end

endmodule
